### rtl/mcbe_pkg.sv
// ----------------------------------------------------------------------------
// mcbe_pkg - shared constants and helpers
// Widths and table layout of the muscle curve Bezier evaluator, plus the
// rounding, saturation and binomial helpers used by the datapath.
// ----------------------------------------------------------------------------
package mcbe_pkg;

  localparam int MAX_SEGMENTS = 5;
  localparam int NUM_CURVES   = 4;
  localparam int FRAC_BITS    = 24;
  localparam int BISECT_STEPS = 32;

  // table layout inside one curve
  localparam int ENDS_BASE  = MAX_SEGMENTS * 12;
  localparam int COUNT_WORD = ENDS_BASE + 6;
  localparam int SEG_W      = $clog2(MAX_SEGMENTS + 1);
  localparam int BI_W       = $clog2(BISECT_STEPS + 1);

  // datapath widths
  localparam int U_W   = FRAC_BITS + 1;     // u, powers and weights, in [0, 1]
  localparam int MA_W  = 33;                // multiplier operand a
  localparam int MB_W  = 34;                // multiplier operand b
  localparam int P_W   = MA_W + MB_W;       // product
  localparam int R_W   = P_W - FRAC_BITS;   // product after rounding
  localparam int ACC_W = 40;                // Bezier sum
  localparam int S_W   = 44;                // wide value before saturation

  localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_BITS;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NEG   = 2'd2;

  // configuration register indexes
  localparam logic REG_TOLERANCE = 1'b0;

  // round to nearest, half up, dropping FRAC_BITS fraction bits
  function automatic logic signed [R_W-1:0] round_frac(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = p + (P_W'(1) <<< (FRAC_BITS - 1));
    return R_W'(t >>> FRAC_BITS);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [S_W-1:0] v);
    logic signed [31:0] r;
    if (v > S_W'(signed'(32'sh7FFF_FFFF)))
      r = 32'sh7FFF_FFFF;
    else if (v < S_W'(signed'(32'sh8000_0000)))
      r = 32'sh8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

  // binomial factor times a rounded term: 1, 5, 10, 10, 5, 1
  function automatic logic signed [ACC_W-1:0] binom_term(input logic [2:0] k,
                                                         input logic signed [R_W-1:0] r);
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] t;
    x = ACC_W'(r);
    case (k)
      3'd1, 3'd4: t = (x <<< 2) + x;
      3'd2, 3'd3: t = (x <<< 3) + (x <<< 1);
      default:    t = x;
    endcase
    return t;
  endfunction

endpackage

### rtl/mcbe_if.sv
// ----------------------------------------------------------------------------
// mcbe_req_if / mcbe_rsp_if - item channels
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface mcbe_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [1:0]         curve_select;
  logic [6:0]         word_index;
  logic signed [31:0] word_value;
  logic signed [31:0] fiber_length;
  logic signed [31:0] fiber_velocity;
  logic signed [31:0] tendon_length;

  modport source (output valid, command, curve_select, word_index, word_value,
                  fiber_length, fiber_velocity, tendon_length, input ready);
  modport sink   (input valid, command, curve_select, word_index, word_value,
                  fiber_length, fiber_velocity, tendon_length, output ready);
endinterface

interface mcbe_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] active_force;
  logic signed [31:0] velocity_factor;
  logic signed [31:0] passive_force;
  logic signed [31:0] tendon_force;
  logic [1:0]         status;

  modport source (output valid, active_force, velocity_factor, passive_force,
                  tendon_force, status, input ready);
  modport sink   (input valid, active_force, velocity_factor, passive_force,
                  tendon_force, status, output ready);
endinterface

### rtl/muscle_curve_bezier_evaluator.sv
// ----------------------------------------------------------------------------
// muscle_curve_bezier_evaluator - piecewise quintic Bezier muscle curves
// Load items fill the curve table; evaluate items run all four curves through
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A load item is handled in the idle state. An evaluate item runs, per curve, the
// end-point checks and the status update, then either a linear extrapolation or
// a segment search (S_SGA and S_SGB for each segment tried), the x and y control
// loads and 33 Bezier evaluations (22 multiplies through the single multiplier,
// a set-up step and an update step) when the curve lands inside its range. The
// multiplier and the single read port of the curve table set the pace of an item.
// The request side is ready only while the sequencer is idle; a finished result
// sits in an output register, so the next item is taken while it waits. No clearing
// pass follows reset.
module muscle_curve_bezier_evaluator (
  input  logic        clk,
  input  logic        rst,
  mcbe_req_if.sink    req,
  mcbe_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_X0, S_X1, S_CHK, S_EXA, S_EXB, S_EXM, S_EXW, S_SGA, S_SGB,
    S_LD, S_LDW, S_BZS, S_MI, S_MW, S_BZE, S_POST, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [7:0] tolerance;

  // curve storage
  logic signed [31:0] table_mem [512];
  logic signed [31:0] rdata;
  logic [8:0]         raddr;
  logic [6:0]         rword;
  logic [mcbe_pkg::SEG_W-1:0] seg_count [4];

  // item registers
  logic signed [31:0] xin [4];
  logic signed [31:0] res [4];
  logic [1:0]         status;
  logic [1:0]         cur;

  // per-curve working registers
  logic signed [31:0] x0, x1, yend;
  logic               side;
  logic               empty;
  logic [mcbe_pkg::SEG_W-1:0] seg;
  logic               yph;
  logic [2:0]         k;
  logic signed [31:0] ctrl [6];
  logic [mcbe_pkg::U_W-1:0] lo, hi, u;
  logic [mcbe_pkg::BI_W-1:0] bi;
  logic [4:0]         ms;
  logic [mcbe_pkg::U_W-1:0] pu [6];
  logic [mcbe_pkg::U_W-1:0] pv [6];
  logic [mcbe_pkg::U_W-1:0] w [6];
  logic signed [mcbe_pkg::ACC_W-1:0] acc;

  // shared multiplier
  logic signed [mcbe_pkg::MA_W-1:0] op_a;
  logic signed [mcbe_pkg::MB_W-1:0] op_b;
  logic signed [mcbe_pkg::P_W-1:0]  prod;
  logic signed [mcbe_pkg::R_W-1:0]  rnd;

  logic signed [31:0] xcur;
  logic [2:0]         pu_idx, pv_idx, wk_idx;
  logic [mcbe_pkg::SEG_W-1:0] ncur;
  logic signed [32:0] dx;
  logic [6:0]         seg_base;
  logic               load_ok;

  assign pready = 1'b1;
  assign req.ready = (state == S_IDLE);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (psel && penable && pwrite && paddr[2] == mcbe_pkg::REG_TOLERANCE) begin
      tolerance <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == mcbe_pkg::REG_TOLERANCE) ? {24'd0, tolerance} : 32'd0;

  // working values of the current curve
  assign xcur     = xin[cur];
  assign ncur     = seg_count[cur];
  assign dx       = 33'(xcur) - 33'(side ? x1 : x0);
  assign seg_base = 7'({seg, 3'b000}) + 7'({seg, 2'b00});
  assign load_ok  = (req.word_index < 7'(mcbe_pkg::COUNT_WORD));

  // table read address
  always_comb begin
    case (state)
      S_X0:    rword = 7'(mcbe_pkg::ENDS_BASE);
      S_X1:    rword = 7'(mcbe_pkg::ENDS_BASE + 1);
      S_EXA:   rword = 7'(mcbe_pkg::ENDS_BASE + 2) + 7'(side);
      S_EXB:   rword = 7'(mcbe_pkg::ENDS_BASE + 4) + 7'(side);
      S_SGA:   rword = seg_base + 7'd5;
      S_LD:    rword = seg_base + (yph ? 7'd6 : 7'd0) + 7'(k);
      default: rword = '0;
    endcase
    raddr = {cur, rword};
  end

  // curve table: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid && req.command == mcbe_pkg::CMD_LOAD && load_ok)
      table_mem[{req.curve_select, req.word_index}] <= req.word_value;
    rdata <= table_mem[raddr];
  end

  // multiplier operand indexes by micro-step
  always_comb begin
    pu_idx = (ms < 5'd5) ? ms[2:0] : 3'(ms - 5'd10);
    pv_idx = (ms < 5'd10) ? 3'(ms - 5'd5) : 3'(5'd15 - ms);
    wk_idx = 3'(ms - 5'd16);
  end

  // operand selection
  always_comb begin
    if (state == S_EXM) begin
      op_a = mcbe_pkg::MA_W'(rdata);
      op_b = mcbe_pkg::MB_W'(dx);
    end else if (ms < 5'd5) begin
      op_a = mcbe_pkg::MA_W'(pu[pu_idx]);
      op_b = mcbe_pkg::MB_W'(u);
    end else if (ms < 5'd10) begin
      op_a = mcbe_pkg::MA_W'(pv[pv_idx]);
      op_b = mcbe_pkg::MB_W'(mcbe_pkg::U_ONE - u);
    end else if (ms < 5'd16) begin
      op_a = mcbe_pkg::MA_W'(pu[pu_idx]);
      op_b = mcbe_pkg::MB_W'(pv[pv_idx]);
    end else begin
      op_a = mcbe_pkg::MA_W'(ctrl[wk_idx]);
      op_b = mcbe_pkg::MB_W'(w[wk_idx]);
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  assign rnd = mcbe_pkg::round_frac(prod);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      for (int i = 0; i < 4; i++) seg_count[i] <= '0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.command == mcbe_pkg::CMD_LOAD) begin
              if (req.word_index == 7'(mcbe_pkg::COUNT_WORD)) begin
                if (req.word_value < 0)
                  seg_count[req.curve_select] <= '0;
                else if (req.word_value > 32'(mcbe_pkg::MAX_SEGMENTS))
                  seg_count[req.curve_select] <= mcbe_pkg::SEG_W'(mcbe_pkg::MAX_SEGMENTS);
                else
                  seg_count[req.curve_select] <= mcbe_pkg::SEG_W'(req.word_value);
              end
            end else begin
              xin[0] <= req.fiber_length;
              xin[1] <= req.fiber_velocity;
              xin[2] <= req.fiber_length;
              xin[3] <= req.tendon_length;
              cur    <= 2'd0;
              status <= mcbe_pkg::ST_OK;
              state  <= S_X0;
            end
          end
        end
        S_X0: begin
          res[cur] <= '0;
          empty    <= 1'b0;
          if (32'(cur) >= 32'(mcbe_pkg::NUM_CURVES))
            state <= S_POST;
          else
            state <= S_X1;
        end
        S_X1: begin
          x0    <= rdata;
          state <= S_CHK;
        end
        // range check and choice of path
        S_CHK: begin
          x1 <= rdata;
          if (ncur == '0 || rdata <= x0) begin
            empty <= 1'b1;
            state <= S_POST;
          end else if (xcur < x0) begin
            side  <= 1'b0;
            state <= S_EXA;
          end else if (xcur > rdata) begin
            side  <= 1'b1;
            state <= S_EXA;
          end else begin
            seg   <= '0;
            state <= S_SGA;
          end
        end
        // linear extrapolation
        S_EXA: state <= S_EXB;
        S_EXB: begin
          yend  <= rdata;
          state <= S_EXM;
        end
        S_EXM: state <= S_EXW;
        S_EXW: begin
          res[cur] <= mcbe_pkg::sat32(mcbe_pkg::S_W'(yend) + mcbe_pkg::S_W'(rnd));
          state    <= S_POST;
        end
        // first covering segment
        S_SGA: state <= S_SGB;
        S_SGB: begin
          if (xcur <= rdata || seg == ncur - 1'b1) begin
            yph   <= 1'b0;
            k     <= '0;
            state <= S_LD;
          end else begin
            seg   <= seg + 1'b1;
            state <= S_SGA;
          end
        end
        // control point load
        S_LD: state <= S_LDW;
        S_LDW: begin
          ctrl[k] <= rdata;
          if (k == 3'd5) begin
            if (!yph) begin
              lo <= '0;
              hi <= mcbe_pkg::U_ONE;
              bi <= '0;
            end
            state <= S_BZS;
          end else begin
            k     <= k + 3'd1;
            state <= S_LD;
          end
        end
        // one Bezier evaluation at the midpoint
        S_BZS: begin
          u     <= mcbe_pkg::U_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
          pu[0] <= mcbe_pkg::U_ONE;
          pv[0] <= mcbe_pkg::U_ONE;
          ms    <= '0;
          acc   <= '0;
          state <= S_MI;
        end
        S_MI: state <= S_MW;
        S_MW: begin
          if (ms < 5'd5)
            pu[3'(ms + 5'd1)] <= rnd[mcbe_pkg::U_W-1:0];
          else if (ms < 5'd10)
            pv[3'(ms - 5'd4)] <= rnd[mcbe_pkg::U_W-1:0];
          else if (ms < 5'd16)
            w[3'(ms - 5'd10)] <= rnd[mcbe_pkg::U_W-1:0];
          else
            acc <= acc + mcbe_pkg::binom_term(wk_idx, rnd);
          if (ms == 5'd21) begin
            state <= S_BZE;
          end else begin
            ms    <= ms + 5'd1;
            state <= S_MI;
          end
        end
        // bisection update or final y
        S_BZE: begin
          if (!yph) begin
            if (acc < mcbe_pkg::ACC_W'(xcur))
              lo <= u;
            else
              hi <= u;
            if (bi == mcbe_pkg::BI_W'(mcbe_pkg::BISECT_STEPS - 1)) begin
              yph   <= 1'b1;
              k     <= '0;
              state <= S_LD;
            end else begin
              bi    <= bi + 1'b1;
              state <= S_BZS;
            end
          end else begin
            res[cur] <= mcbe_pkg::sat32(mcbe_pkg::S_W'(acc));
            state    <= S_POST;
          end
        end
        // tolerance and status, then next curve
        S_POST: begin
          if (empty) begin
            status <= mcbe_pkg::ST_EMPTY;
          end else if (res[cur] < 0) begin
            if ((33'(res[cur]) + signed'(33'(tolerance))) >= 0)
              res[cur] <= '0;
            else if (status == mcbe_pkg::ST_OK)
              status <= mcbe_pkg::ST_NEG;
          end
          if (cur == 2'd3) begin
            state <= S_DONE;
          end else begin
            cur   <= cur + 2'd1;
            state <= S_X0;
          end
        end
        // hand the result to the output register
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.active_force    <= res[0];
            rsp.velocity_factor <= res[1];
            rsp.passive_force   <= res[2];
            rsp.tendon_force    <= res[3];
            rsp.status          <= status;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/mcbe_test_pkg.sv
// ----------------------------------------------------------------------------
// mcbe_test_pkg - item types for the curve evaluator testbench
// Request and result item records shared by the stimulus, the predictor and
// the result checker.
// ----------------------------------------------------------------------------
package mcbe_test_pkg;

  typedef struct {
    logic              command;
    logic [1:0]        curve_select;
    logic [6:0]        word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] fiber_length;
    logic signed [31:0] fiber_velocity;
    logic signed [31:0] tendon_length;
  } curve_req_t;

  typedef struct {
    logic signed [31:0] active_force;
    logic signed [31:0] velocity_factor;
    logic signed [31:0] passive_force;
    logic signed [31:0] tendon_force;
    logic [1:0]         status;
  } curve_rsp_t;

endpackage

### dv/muscle_curve_bezier_evaluator_test.sv
// ----------------------------------------------------------------------------
// muscle_curve_bezier_evaluator_test - self-checking testbench
// Fills the four curve tables, then sends directed and random load and
// evaluate items with random idling on both sides. Every evaluate item is
// predicted by a bit-exact model of the Bezier arithmetic held here, and each
// result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module muscle_curve_bezier_evaluator_test;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     HOLD_CYCLES = 20_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mcbe_req_if req_ch ();
  mcbe_rsp_if rsp_ch ();

  muscle_curve_bezier_evaluator i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state and arithmetic
  // --------------------------------------------------------------------------
  int         curve_words [512];
  int         seg_count [4];
  int unsigned tol_lsbs;

  mcbe_test_pkg::curve_req_t pending_items [$];
  mcbe_test_pkg::curve_rsp_t expected_forces [$];

  int unsigned errors, loads_sent, evals_sent, results_checked;
  logic        quiet = 1'b0;
  logic        hold_armed = 1'b0;

  // append to the tail of the stimulus queue
  function automatic void queue_item(mcbe_test_pkg::curve_req_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic longint unsigned mul_round_u(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (mcbe_pkg::FRAC_BITS - 1))) >> mcbe_pkg::FRAC_BITS;
  endfunction

  // round half up and drop the fraction; >>> floors on signed values
  function automatic longint round_frac_s(longint v);
    return (v + (64'sd1 <<< (mcbe_pkg::FRAC_BITS - 1))) >>> mcbe_pkg::FRAC_BITS;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint curve_word(int c, int w);
    return longint'(curve_words[(c * 128 + w) & 511]);
  endfunction

  function automatic longint bezier_sum(int c, int base, longint unsigned u);
    longint unsigned one;
    longint unsigned pu [6];
    longint unsigned pv [6];
    longint unsigned wgt;
    longint          sum;
    longint          binom [6];
    one = 64'd1 << mcbe_pkg::FRAC_BITS;
    binom = '{1, 5, 10, 10, 5, 1};
    pu[0] = one;
    pv[0] = one;
    for (int k = 1; k < 6; k++) begin
      pu[k] = mul_round_u(pu[k-1], u);
      pv[k] = mul_round_u(pv[k-1], one - u);
    end
    sum = 0;
    for (int k = 0; k < 6; k++) begin
      wgt = mul_round_u(pu[k], pv[5-k]);
      sum += binom[k] * round_frac_s(curve_word(c, base + k) * longint'(wgt));
    end
    return sum;
  endfunction

  // returns 0 for a curve with no segments or an empty x range
  function automatic bit curve_value(int c, int x, output int r);
    int              n;
    longint          x0, x1;
    int              seg;
    longint unsigned lo, hi, mid;
    n  = seg_count[c];
    x0 = curve_word(c, mcbe_pkg::ENDS_BASE + 0);
    x1 = curve_word(c, mcbe_pkg::ENDS_BASE + 1);
    r  = 0;
    if (n == 0 || x1 <= x0) return 1'b0;
    if (x < x0) begin
      r = clamp32(curve_word(c, mcbe_pkg::ENDS_BASE + 2) +
                  round_frac_s(curve_word(c, mcbe_pkg::ENDS_BASE + 4) * (longint'(x) - x0)));
      return 1'b1;
    end
    if (x > x1) begin
      r = clamp32(curve_word(c, mcbe_pkg::ENDS_BASE + 3) +
                  round_frac_s(curve_word(c, mcbe_pkg::ENDS_BASE + 5) * (longint'(x) - x1)));
      return 1'b1;
    end
    // first segment whose last x control covers the input, else the last one
    seg = n - 1;
    for (int i = 0; i < n; i++) begin
      if (longint'(x) <= curve_word(c, i * 12 + 5)) begin
        seg = i;
        break;
      end
    end
    lo = 0;
    hi = 64'd1 << mcbe_pkg::FRAC_BITS;
    for (int i = 0; i < mcbe_pkg::BISECT_STEPS; i++) begin
      mid = (lo + hi) >> 1;
      if (bezier_sum(c, seg * 12, mid) < longint'(x)) lo = mid;
      else hi = mid;
    end
    r = clamp32(bezier_sum(c, seg * 12 + 6, (lo + hi) >> 1));
    return 1'b1;
  endfunction

  function automatic mcbe_test_pkg::curve_rsp_t predict_forces(mcbe_test_pkg::curve_req_t it);
    mcbe_test_pkg::curve_rsp_t res;
    int         xs [4];
    int         r [4];
    logic [1:0] st;
    xs[0] = it.fiber_length;
    xs[1] = it.fiber_velocity;
    xs[2] = it.fiber_length;
    xs[3] = it.tendon_length;
    st = mcbe_pkg::ST_OK;
    for (int c = 0; c < 4; c++) begin
      r[c] = 0;
      if (c < mcbe_pkg::NUM_CURVES) begin
        if (!curve_value(c, xs[c], r[c])) begin
          st = mcbe_pkg::ST_EMPTY;
        end else if (r[c] < 0) begin
          if (longint'(r[c]) >= -longint'(tol_lsbs)) r[c] = 0;
          else if (st == mcbe_pkg::ST_OK) st = mcbe_pkg::ST_NEG;
        end
      end
    end
    res.active_force    = r[0];
    res.velocity_factor = r[1];
    res.passive_force   = r[2];
    res.tendon_force    = r[3];
    res.status          = st;
    return res;
  endfunction

  // model update for one accepted item
  task automatic take_item(mcbe_test_pkg::curve_req_t it);
    int v;
    if (it.command == mcbe_pkg::CMD_EVAL) begin
      expected_forces.insert(expected_forces.size(), predict_forces(it));
      evals_sent++;
      return;
    end
    loads_sent++;
    if (int'(it.curve_select) >= mcbe_pkg::NUM_CURVES ||
        int'(it.word_index) > mcbe_pkg::COUNT_WORD) return;
    if (int'(it.word_index) == mcbe_pkg::COUNT_WORD) begin
      v = it.word_value;
      if (v < 0) v = 0;
      if (v > mcbe_pkg::MAX_SEGMENTS) v = mcbe_pkg::MAX_SEGMENTS;
      seg_count[it.curve_select] = v;
    end else begin
      curve_words[(int'(it.curve_select) * 128 + int'(it.word_index)) & 511] = it.word_value;
    end
  endtask

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  mcbe_test_pkg::curve_req_t cur_item;
  int         req_gap;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid          <= 1'b0;
      req_ch.command        <= mcbe_pkg::CMD_LOAD;
      req_ch.curve_select   <= '0;
      req_ch.word_index     <= '0;
      req_ch.word_value     <= '0;
      req_ch.fiber_length   <= '0;
      req_ch.fiber_velocity <= '0;
      req_ch.tendon_length  <= '0;
      req_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) take_item(cur_item);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          req_ch.command        <= cur_item.command;
          req_ch.curve_select   <= cur_item.curve_select;
          req_ch.word_index     <= cur_item.word_index;
          req_ch.word_value     <= cur_item.word_value;
          req_ch.fiber_length   <= cur_item.fiber_length;
          req_ch.fiber_velocity <= cur_item.fiber_velocity;
          req_ch.tendon_length  <= cur_item.tendon_length;
          req_ch.valid          <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 14);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor and checker
  // --------------------------------------------------------------------------
  int hold_left;
  bit hold_done;
  int rsp_gap;

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             results_checked, field, got, want);
    errors++;
  endtask

  // long receiver hold-off so that the block fills up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    mcbe_test_pkg::curve_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_forces.size() == 0) begin
          report_mismatch("queued predictions", 0, 1);
        end else begin
          want = expected_forces.pop_front();
          if (rsp_ch.active_force !== want.active_force)
            report_mismatch("active_force", longint'(rsp_ch.active_force),
                            longint'(want.active_force));
          if (rsp_ch.velocity_factor !== want.velocity_factor)
            report_mismatch("velocity_factor", longint'(rsp_ch.velocity_factor),
                            longint'(want.velocity_factor));
          if (rsp_ch.passive_force !== want.passive_force)
            report_mismatch("passive_force", longint'(rsp_ch.passive_force),
                            longint'(want.passive_force));
          if (rsp_ch.tendon_force !== want.tendon_force)
            report_mismatch("tendon_force", longint'(rsp_ch.tendon_force),
                            longint'(want.tendon_force));
          if (rsp_ch.status !== want.status)
            report_mismatch("status", longint'(rsp_ch.status), longint'(want.status));
        end
        results_checked++;
      end
      if (rsp_gap > 0) rsp_gap--;
      else if (!quiet && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 14);
      rsp_ch.ready <= (rsp_gap == 0) && (hold_left == 0);
    end
  end

  // cycle limit
  longint cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit after %0d results", results_checked);
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int lo_x [4];
  int hi_x [4];
  int seg_end [4][mcbe_pkg::MAX_SEGMENTS];

  function automatic mcbe_test_pkg::curve_req_t load_item(int c, int w, int v);
    mcbe_test_pkg::curve_req_t it;
    it.command        = mcbe_pkg::CMD_LOAD;
    it.curve_select   = c[1:0];
    it.word_index     = w[6:0];
    it.word_value     = v;
    it.fiber_length   = $urandom;
    it.fiber_velocity = $urandom;
    it.tendon_length  = $urandom;
    return it;
  endfunction

  function automatic mcbe_test_pkg::curve_req_t eval_item(int fl, int fv, int tl);
    mcbe_test_pkg::curve_req_t it;
    it.command        = mcbe_pkg::CMD_EVAL;
    it.curve_select   = 2'($urandom);
    it.word_index     = 7'($urandom);
    it.word_value     = $urandom;
    it.fiber_length   = fl;
    it.fiber_velocity = fv;
    it.tendon_length  = tl;
    return it;
  endfunction

  function automatic int rand_y(int mode);
    case (mode)
      0:       return $signed($urandom_range(0, 600)) - 300;
      1:       return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return $urandom;
    endcase
  endfunction

  // a whole curve: monotone x controls over contiguous segments
  task automatic build_curve(int c, int nseg, bit empty_range);
    int x, span, ymode, xs [6];
    int x0, x1;
    ymode = $urandom_range(0, 3);
    x0 = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0300_0000;
    x = x0;
    for (int s = 0; s < mcbe_pkg::MAX_SEGMENTS; s++) begin
      span = $urandom_range(32'h0010_0000, 32'h0100_0000);
      xs[0] = x;
      xs[5] = x + span;
      for (int k = 1; k < 5; k++) xs[k] = xs[k-1] + $urandom_range(0, (xs[5] - xs[k-1]) / 2);
      for (int k = 0; k < 6; k++) queue_item(load_item(c, s * 12 + k, xs[k]));
      for (int k = 0; k < 6; k++)
        queue_item(load_item(c, s * 12 + 6 + k, rand_y(ymode)));
      seg_end[c][s] = xs[5];
      if (s < nseg) x = xs[5];
    end
    x1 = empty_range ? x0 - $urandom_range(0, 1000) : x;
    if (!empty_range && $urandom_range(0, 5) == 0) x1 = x + $urandom_range(1, 32'h0080_0000);
    lo_x[c] = x0;
    hi_x[c] = x1;
    queue_item(load_item(c, mcbe_pkg::ENDS_BASE + 0, x0));
    queue_item(load_item(c, mcbe_pkg::ENDS_BASE + 1, x1));
    queue_item(load_item(c, mcbe_pkg::ENDS_BASE + 2, rand_y(ymode)));
    queue_item(load_item(c, mcbe_pkg::ENDS_BASE + 3, rand_y(ymode)));
    queue_item(load_item(c, mcbe_pkg::ENDS_BASE + 4, ($urandom_range(0, 3) == 0) ?
                         $urandom : rand_y(1)));
    queue_item(load_item(c, mcbe_pkg::ENDS_BASE + 5, ($urandom_range(0, 3) == 0) ?
                         $urandom : rand_y(1)));
    queue_item(load_item(c, mcbe_pkg::COUNT_WORD, nseg));
  endtask

  function automatic int pick_x(int c);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return lo_x[c] - $urandom_range(0, 32'h0200_0000);
      2:       return hi_x[c] + $urandom_range(0, 32'h0200_0000);
      3:       return seg_end[c][$urandom_range(0, mcbe_pkg::MAX_SEGMENTS - 1)];
      default: return (hi_x[c] > lo_x[c]) ? lo_x[c] + $urandom_range(0, hi_x[c] - lo_x[c])
                                          : lo_x[c];
    endcase
  endfunction

  task automatic random_items(int count);
    int r, c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      c = $urandom_range(0, 3);
      if (r < 2) begin
        build_curve(c, $urandom_range(0, 10) == 0 ? 0 :
                    $urandom_range(1, mcbe_pkg::MAX_SEGMENTS),
                    $urandom_range(0, 15) == 0);
        i += 66;
      end else if (r < 27) begin
        queue_item(eval_item(pick_x($urandom_range(0, 1) ? 0 : 2), pick_x(1), pick_x(3)));
      end else if (r < 30) begin
        // segment count, out of range at times
        queue_item(load_item(c, mcbe_pkg::COUNT_WORD, $urandom_range(0, 1) ?
                             $urandom_range(1, mcbe_pkg::MAX_SEGMENTS) : $urandom));
      end else if (r < 36) begin
        // ignored words beyond the count word
        queue_item(load_item(c, $urandom_range(mcbe_pkg::COUNT_WORD + 1, 127), $urandom));
      end else begin
        // y control tweak keeps the curve usable
        queue_item(load_item(c, $urandom_range(0, mcbe_pkg::MAX_SEGMENTS - 1) * 12 +
                             $urandom_range(6, 11), rand_y($urandom_range(0, 2))));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || req_ch.valid || expected_forces.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_tolerance(int unsigned v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * mcbe_pkg::REG_TOLERANCE);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol_lsbs = v & 32'hFF;
  endtask

  initial begin
    tol_lsbs = 0;
    foreach (curve_words[i]) curve_words[i] = 0;
    foreach (seg_count[i]) seg_count[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_tolerance(0);

    // every table word of every curve written before any evaluation
    for (int c = 0; c < 4; c++) build_curve(c, c + 1, 1'b0);

    // directed: range ends, extremes, extrapolation, segment ends, count clamps
    queue_item(eval_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    queue_item(eval_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    queue_item(eval_item(lo_x[0], lo_x[1], lo_x[3]));
    queue_item(eval_item(hi_x[2], hi_x[1], hi_x[3]));
    queue_item(eval_item(seg_end[0][0], seg_end[1][0], seg_end[3][1]));
    queue_item(eval_item(seg_end[2][1] + 1, lo_x[1] - 1, hi_x[3] + 1));
    queue_item(load_item(1, mcbe_pkg::COUNT_WORD, -5));
    queue_item(load_item(3, mcbe_pkg::COUNT_WORD, 9));
    queue_item(load_item(2, 127, 32'h1234_5678));
    queue_item(load_item(0, mcbe_pkg::COUNT_WORD + 1, -1));
    queue_item(eval_item(pick_x(0), pick_x(1), pick_x(3)));
    queue_item(load_item(2, mcbe_pkg::ENDS_BASE + 1, lo_x[2]));
    queue_item(eval_item(pick_x(2), pick_x(1), pick_x(3)));
    queue_item(load_item(2, mcbe_pkg::ENDS_BASE + 1, hi_x[2]));
    queue_item(load_item(1, mcbe_pkg::COUNT_WORD, 2));
    queue_item(eval_item(pick_x(0), pick_x(1), pick_x(3)));
    wait_idle();

    // random phases across tolerance settings
    write_tolerance(255);
    hold_armed <= 1'b1;
    random_items(330);
    wait_idle();
    write_tolerance($urandom_range(1, 254));
    random_items(330);
    wait_idle();
    write_tolerance(1);
    random_items(330);
    wait_idle();
    write_tolerance(32'hFFFF_FF00 | $urandom_range(0, 255));
    quiet <= 1'b1;
    random_items(330);
    wait_idle();
    repeat (200) @(posedge clk);

    $display("sent %0d load items and %0d evaluate items, checked %0d results",
             loads_sent, evals_sent, results_checked);
    $display("tolerance settings 0, 255, 1 and random; one long receiver hold-off");
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
